@@ rtl/vertex_transform_4x4_assert.svh @@
// ---------------------------------------------------------------------------
// Vertex transform assertion macros
// Shared property forms for the checker of the vertex transform block.
// ---------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VT_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("vertex_transform_4x4: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VT_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("vertex_transform_4x4: check failed");

`endif

@@ rtl/vt_pkg.sv @@
// ---------------------------------------------------------------------------
// Vertex transform package
// Widths, operation codes, register reset values and pipeline types.
// ---------------------------------------------------------------------------
package vt_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DW        = 32;
  localparam int unsigned PW        = 2 * DW;
  localparam int unsigned SW        = PW + 2;
  localparam int unsigned NUM_W     = DW + FRAC_BITS;
  localparam int unsigned NREGS     = 8;
  localparam int unsigned RW        = 64;
  localparam int unsigned AW        = 6;
  localparam int unsigned IDX_W     = 3;

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_DIVIDE = 2'd1,
    OP_DIR    = 2'd2,
    OP_VEC4   = 2'd3
  } vt_op_e;

  typedef logic signed [DW-1:0] fx_t;

  localparam fx_t ONE_FX = DW'(64'd1 << FRAC_BITS);
  localparam logic [RW-1:0] ONE_LO = RW'(64'd1 << FRAC_BITS);
  localparam logic [RW-1:0] ONE_HI = RW'(64'd1 << (FRAC_BITS + DW));

  localparam logic [RW-1:0] REG_RESET [NREGS] = '{
    ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
  };

  typedef struct packed {
    logic [NUM_W-1:0] nq;
    logic [DW-1:0]    rem;
  } vt_lane_t;

  typedef struct packed {
    vt_lane_t [2:0] lane;
    logic [2:0]     neg;
    logic [DW-1:0]  den;
    fx_t [3:0]      res;
    vt_op_e         op;
    logic           zero;
  } vt_div_t;

endpackage

@@ rtl/vt_regs.sv @@
// ---------------------------------------------------------------------------
// Vertex transform matrix registers
// APB register file holding the eight 64-bit matrix registers.
// ---------------------------------------------------------------------------
module vt_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [vt_pkg::AW-1:0]                 paddr,
  input  logic [vt_pkg::RW-1:0]                 pwdata,
  output logic [vt_pkg::RW-1:0]                 prdata,
  output logic                                  pready,
  output logic [vt_pkg::NREGS-1:0][vt_pkg::RW-1:0] mat_o
);
  import vt_pkg::*;

  logic [RW-1:0]    regs_q [NREGS];
  logic [RW-1:0]    regs_d [NREGS];
  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[AW-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = regs_q[idx];

  always_comb begin
    for (int i = 0; i < NREGS; i++) begin
      regs_d[i] = regs_q[i];
      mat_o[i]  = regs_q[i];
    end
    if (wr) begin
      regs_d[idx] = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREGS; i++) regs_q[i] <= REG_RESET[i];
    end else begin
      for (int i = 0; i < NREGS; i++) regs_q[i] <= regs_d[i];
    end
  end

endmodule

@@ rtl/vt_mac.sv @@
// ---------------------------------------------------------------------------
// Vertex transform multiply-accumulate stages
// Products, column sums, then rounding and saturation, one register each.
// ---------------------------------------------------------------------------
module vt_mac (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  vt_pkg::vt_op_e                           op_i,
  input  vt_pkg::fx_t [3:0]                        vec_i,
  input  logic [vt_pkg::NREGS-1:0][vt_pkg::RW-1:0] mat_i,
  output logic                                     valid_o,
  output vt_pkg::vt_op_e                           op_o,
  output vt_pkg::fx_t [3:0]                        res_o
);
  import vt_pkg::*;

  localparam logic signed [SW-1:0] MAXV = SW'(32'h7fffffff);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);
  localparam logic signed [SW-1:0] RND  = SW'(1) << (FRAC_BITS - 1);

  fx_t                    v [4];
  logic signed [PW-1:0]   prod_d [4][4];
  logic signed [PW-1:0]   prod_q [4][4];
  logic signed [SW-1:0]   sum_d [4];
  logic signed [SW-1:0]   sum_q [4];
  fx_t [3:0]              res_d;
  fx_t [3:0]              res_q;
  vt_op_e                 op1_q, op2_q, op3_q;
  logic                   vld1_q, vld2_q, vld3_q;

  always_comb begin
    v[0] = vec_i[0];
    v[1] = vec_i[1];
    v[2] = vec_i[2];
    case (op_i)
      OP_VEC4: v[3] = vec_i[3];
      OP_DIR:  v[3] = '0;
      default: v[3] = ONE_FX;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_d[r][c] = PW'(v[r]) *
                       PW'($signed(mat_i[2 * r + (c >> 1)][DW * (c & 1) +: DW]));
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_d[c] = SW'(prod_q[0][c]) + SW'(prod_q[1][c]) +
                 SW'(prod_q[2][c]) + SW'(prod_q[3][c]);
    end
  end

  always_comb begin
    logic signed [SW-1:0] sh;
    for (int c = 0; c < 4; c++) begin
      sh = (sum_q[c] + RND) >>> FRAC_BITS;
      if (sh > MAXV) begin
        res_d[c] = MAXV[DW-1:0];
      end else if (sh < MINV) begin
        res_d[c] = MINV[DW-1:0];
      end else begin
        res_d[c] = sh[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
      res_q  <= res_d;
      op1_q  <= op_i;
      op2_q  <= op1_q;
      op3_q  <= op2_q;
    end
  end

  assign valid_o = vld3_q;
  assign op_o    = op3_q;
  assign res_o   = res_q;

endmodule

@@ rtl/vt_div.sv @@
// ---------------------------------------------------------------------------
// Vertex transform divide pipeline
// Operand setup, one quotient bit per stage for three lanes, and the
// final sign, saturation and result selection into the output register.
// ---------------------------------------------------------------------------
module vt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  vt_pkg::vt_op_e    op_i,
  input  vt_pkg::fx_t [3:0] res_i,
  output logic              valid_o,
  output vt_pkg::fx_t [3:0] out_o,
  output logic              zero_o
);
  import vt_pkg::*;

  localparam logic [NUM_W-1:0] QMAX = NUM_W'(32'h7fffffff);
  localparam logic [NUM_W-1:0] QMIN = NUM_W'(32'h80000000);

  function automatic vt_lane_t div_step(vt_lane_t l, logic [DW-1:0] den);
    logic [DW:0] trial;
    logic [DW:0] diff;
    vt_lane_t    o;
    trial = {l.rem, l.nq[NUM_W-1]};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      o.rem = diff[DW-1:0];
      o.nq  = {l.nq[NUM_W-2:0], 1'b1};
    end else begin
      o.rem = trial[DW-1:0];
      o.nq  = {l.nq[NUM_W-2:0], 1'b0};
    end
    return o;
  endfunction

  vt_div_t     prep_d;
  vt_div_t     st_q [NUM_W+1];
  logic        vld_q [NUM_W+1];
  fx_t [3:0]   out_d;
  fx_t [3:0]   out_q;
  logic        zero_d, zero_q, out_vld_q;

  always_comb begin
    fx_t           w;
    logic [DW-1:0] absn;
    w            = res_i[3];
    prep_d.res   = res_i;
    prep_d.op    = op_i;
    prep_d.zero  = (w == '0);
    prep_d.den   = w[DW-1] ? DW'(-w) : DW'(w);
    for (int c = 0; c < 3; c++) begin
      prep_d.neg[c] = res_i[c][DW-1] ^ w[DW-1];
      absn = res_i[c][DW-1] ? DW'(-res_i[c]) : DW'(res_i[c]);
      prep_d.lane[c].nq  = {absn, {FRAC_BITS{1'b0}}} + NUM_W'(prep_d.den >> 1);
      prep_d.lane[c].rem = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= prep_d;
  end

  for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
    vt_div_t nxt;
    always_comb begin
      nxt = st_q[k-1];
      for (int c = 0; c < 3; c++) begin
        nxt.lane[c] = div_step(st_q[k-1].lane[c], st_q[k-1].den);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[k] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NUM_W; k++) vld_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= NUM_W; k++) vld_q[k] <= vld_q[k-1];
      out_vld_q <= vld_q[NUM_W];
    end
  end

  always_comb begin
    vt_div_t          s;
    logic [NUM_W-1:0] q;
    fx_t [2:0]        quo;
    s = st_q[NUM_W];
    for (int c = 0; c < 3; c++) begin
      q = s.lane[c].nq;
      if (s.neg[c]) begin
        quo[c] = (q > QMIN) ? fx_t'(QMIN[DW-1:0]) : fx_t'(DW'(-q));
      end else begin
        quo[c] = (q > QMAX) ? fx_t'(QMAX[DW-1:0]) : fx_t'(q[DW-1:0]);
      end
    end
    zero_d = 1'b0;
    out_d  = s.res;
    case (s.op)
      OP_DIVIDE: begin
        if (s.zero) begin
          out_d  = '0;
          zero_d = 1'b1;
        end else begin
          out_d[0] = quo[0];
          out_d[1] = quo[1];
          out_d[2] = quo[2];
        end
      end
      OP_DIR: begin
        out_d[3] = '0;
      end
      default: begin
        out_d = s.res;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q  <= out_d;
      zero_q <= zero_d;
    end
  end

  assign valid_o = out_vld_q;
  assign out_o   = out_q;
  assign zero_o  = zero_q;

endmodule

@@ rtl/vertex_transform_4x4.sv @@
// ---------------------------------------------------------------------------
// Vertex transform 4x4
// Row vector times configured matrix with optional perspective divide.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata {w,z,y,x}, tuser operation
//   m_axis    out        tdata {w,z,y,x}, tuser zero divisor flag
//   apb       in/out     eight 64-bit matrix registers at 8*i
//
// One transfer is taken every cycle unless the output stalls; it passes
// three multiply and sum stages, one divide setup stage, 48 quotient bit
// stages and the output register. The quotient stages set the depth.
// Reset clears all valid bits and loads the identity matrix.
// A stall on the output freezes the whole pipeline in place.
// ---------------------------------------------------------------------------
module vertex_transform_4x4 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [127:0]              s_axis_tdata,   // in_x, in_y, in_z, in_w
  input  logic [1:0]                s_axis_tuser,   // operation
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [127:0]              m_axis_tdata,   // out_x, out_y, out_z, out_w
  output logic [0:0]                m_axis_tuser,   // zero_divisor
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vt_pkg::AW-1:0]     paddr,
  input  logic [vt_pkg::RW-1:0]     pwdata,
  output logic [vt_pkg::RW-1:0]     prdata,
  output logic                      pready
);
  import vt_pkg::*;

  logic [NREGS-1:0][RW-1:0] mat;
  logic                     en;
  logic                     mac_vld;
  vt_op_e                   mac_op;
  fx_t [3:0]                mac_res;
  fx_t [3:0]                vec;
  fx_t [3:0]                out;
  logic                     zero;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign vec           = s_axis_tdata;

  vt_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .mat_o  (mat)
  );

  vt_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_axis_tvalid),
    .op_i   (vt_op_e'(s_axis_tuser)),
    .vec_i  (vec),
    .mat_i  (mat),
    .valid_o(mac_vld),
    .op_o   (mac_op),
    .res_o  (mac_res)
  );

  vt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(mac_vld),
    .op_i   (mac_op),
    .res_i  (mac_res),
    .valid_o(m_axis_tvalid),
    .out_o  (out),
    .zero_o (zero)
  );

  assign m_axis_tdata    = out;
  assign m_axis_tuser[0] = zero;

endmodule

@@ rtl/vt_checker.sv @@
// ---------------------------------------------------------------------------
// Vertex transform port checker
// Checks output stability, flow control and the zero divisor result.
// ---------------------------------------------------------------------------
`include "vertex_transform_4x4_assert.svh"

module vt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  `VT_ASSERT_IMP(a_zero_div_clears, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 128'd0)
  `VT_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  `VT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind vertex_transform_4x4 vt_checker u_vt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
